>>> rtl/core/fasmd_pkg.sv
// Shared types, codes and the operand decoder of the floating-point unit.
// Depends on nothing; every other file of the unit uses it by scoped names.
package fasmd_pkg;

    // Result classes.
    localparam logic [1:0] KIND_FIN  = 2'd0;
    localparam logic [1:0] KIND_ZERO = 2'd1;
    localparam logic [1:0] KIND_INF  = 2'd2;
    localparam logic [1:0] KIND_NAN  = 2'd3;

    // Command codes; unused codes behave as pass-through.
    localparam logic [2:0] CMD_MUL  = 3'd0;
    localparam logic [2:0] CMD_DIV  = 3'd1;
    localparam logic [2:0] CMD_ADD  = 3'd2;
    localparam logic [2:0] CMD_SUB  = 3'd3;
    localparam logic [2:0] CMD_PASS = 3'd4;

    // Rounding modes.
    localparam logic [1:0] RM_ZERO = 2'd0;
    localparam logic [1:0] RM_NEAR = 2'd1;
    localparam logic [1:0] RM_UP   = 2'd2;
    localparam logic [1:0] RM_DOWN = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_FORMAT = 1'b0;
    localparam logic CFG_ROUND  = 1'b1;

    // Work that the back end carries out for one beat.
    typedef enum logic [2:0] {
        OP_SPEC = 3'd0,
        OP_PASS = 3'd1,
        OP_MUL  = 3'd2,
        OP_DIV  = 3'd3,
        OP_ADD  = 3'd4
    } op_t;

    typedef logic signed [9:0]  fexp_t;
    typedef logic signed [11:0] wexp_t;

    // Decoded operand: value is mant * 2^exp, mant has its top bit at bit 23.
    typedef struct packed {
        logic [1:0]  kind;
        logic        sign;
        logic [23:0] mant;
        fexp_t       exp;
    } operand_t;

    // One classified beat held in the queue.
    typedef struct packed {
        op_t         op;
        logic        sign;
        logic [1:0]  kind;
        logic        sign_b;
        logic [23:0] mant_a;
        fexp_t       exp_a;
        logic [23:0] mant_b;
        fexp_t       exp_b;
    } entry_t;

    // Unpack a bit pattern and normalise subnormal significands.
    function automatic operand_t decode(input logic [31:0] bits, input logic half);
        operand_t    r;
        logic [7:0]  ex;
        logic [7:0]  exx;
        logic        all_ones;
        logic        frac_nz;
        logic        hid;
        logic [23:0] raw;
        fexp_t       e0;
        logic [4:0]  lz;
        logic        found;
        if (half) begin
            r.sign   = bits[15];
            ex       = {3'b000, bits[14:10]};
            all_ones = &bits[14:10];
            frac_nz  = |bits[9:0];
        end
        else begin
            r.sign   = bits[31];
            ex       = bits[30:23];
            all_ones = &bits[30:23];
            frac_nz  = |bits[22:0];
        end
        if (all_ones) begin
            r.kind = frac_nz ? KIND_NAN : KIND_INF;
        end
        else if (ex == 8'd0 && !frac_nz) begin
            r.kind = KIND_ZERO;
        end
        else begin
            r.kind = KIND_FIN;
        end
        hid = (ex != 8'd0);
        raw = half ? {13'b0, hid, bits[9:0]} : {hid, bits[22:0]};
        exx = hid ? ex : 8'd1;
        e0  = $signed({2'b00, exx}) - (half ? 10'sd25 : 10'sd150);
        // Leading-zero count over the significand.
        lz    = 5'd0;
        found = 1'b0;
        for (int i = 23; i >= 0; i--) begin
            if (!found && raw[i]) begin
                lz    = 5'(23 - i);
                found = 1'b1;
            end
        end
        r.mant = raw << lz;
        r.exp  = e0 - $signed({5'b00000, lz});
        return r;
    endfunction

endpackage

>>> rtl/core/fasmd_front.sv
// Front end: takes input beats, decodes both operands and settles all
// special cases. Depends on fasmd_pkg.
module fasmd_front (
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           cmd,
    input  logic [31:0]          operand_a,
    input  logic [31:0]          operand_b,
    input  logic                 format_half,
    input  logic [1:0]           rounding_mode,
    input  logic                 queue_full,
    output logic                 push,
    output fasmd_pkg::entry_t    entry
);

    fasmd_pkg::operand_t a;
    fasmd_pkg::operand_t b;
    logic na, nb, ia, ib, za, zb;
    logic sx;
    logic sb;

    // Handshake towards the queue.
    assign in_ready = !queue_full;
    assign push     = in_valid && !queue_full;

    // Operand decode.
    assign a  = fasmd_pkg::decode(operand_a, format_half);
    assign b  = fasmd_pkg::decode(operand_b, format_half);
    assign na = (a.kind == fasmd_pkg::KIND_NAN);
    assign nb = (b.kind == fasmd_pkg::KIND_NAN);
    assign ia = (a.kind == fasmd_pkg::KIND_INF);
    assign ib = (b.kind == fasmd_pkg::KIND_INF);
    assign za = (a.kind == fasmd_pkg::KIND_ZERO);
    assign zb = (b.kind == fasmd_pkg::KIND_ZERO);
    assign sx = a.sign ^ b.sign;
    assign sb = b.sign ^ (cmd == fasmd_pkg::CMD_SUB);

    // Classification of the beat into the work the back end must do.
    always_comb
    begin
        entry        = '0;
        entry.mant_a = a.mant;
        entry.exp_a  = a.exp;
        entry.mant_b = b.mant;
        entry.exp_b  = b.exp;
        entry.sign   = sx;
        entry.sign_b = sb;
        entry.kind   = fasmd_pkg::KIND_FIN;
        entry.op     = fasmd_pkg::OP_SPEC;
        case (cmd)
            fasmd_pkg::CMD_MUL:
            begin
                if (na || nb || (ia && zb) || (za && ib)) begin
                    entry.kind = fasmd_pkg::KIND_NAN;
                end
                else if (ia || ib) begin
                    entry.kind = fasmd_pkg::KIND_INF;
                end
                else if (za || zb) begin
                    entry.kind = fasmd_pkg::KIND_ZERO;
                end
                else begin
                    entry.op = fasmd_pkg::OP_MUL;
                end
            end
            fasmd_pkg::CMD_DIV:
            begin
                if (na || nb || (za && zb) || (ia && ib)) begin
                    entry.kind = fasmd_pkg::KIND_NAN;
                end
                else if (ia || zb) begin
                    entry.kind = fasmd_pkg::KIND_INF;
                end
                else if (za || ib) begin
                    entry.kind = fasmd_pkg::KIND_ZERO;
                end
                else begin
                    entry.op = fasmd_pkg::OP_DIV;
                end
            end
            fasmd_pkg::CMD_ADD, fasmd_pkg::CMD_SUB:
            begin
                if (na || nb) begin
                    entry.kind = fasmd_pkg::KIND_NAN;
                end
                else if (ia || ib) begin
                    if (ia && ib && (a.sign != sb)) begin
                        entry.kind = fasmd_pkg::KIND_NAN;
                    end
                    else begin
                        entry.kind = fasmd_pkg::KIND_INF;
                        entry.sign = ia ? a.sign : sb;
                    end
                end
                else if (za && zb) begin
                    entry.kind = fasmd_pkg::KIND_ZERO;
                    entry.sign = (a.sign == sb) ? a.sign
                               : (rounding_mode == fasmd_pkg::RM_DOWN);
                end
                else if (za) begin
                    // Only the second operand counts: round it on its own.
                    entry.op     = fasmd_pkg::OP_PASS;
                    entry.sign   = sb;
                    entry.mant_a = b.mant;
                    entry.exp_a  = b.exp;
                end
                else if (zb) begin
                    entry.op   = fasmd_pkg::OP_PASS;
                    entry.sign = a.sign;
                end
                else begin
                    entry.op   = fasmd_pkg::OP_ADD;
                    entry.sign = a.sign;
                end
            end
            default:
            begin
                entry.sign = a.sign;
                if (a.kind == fasmd_pkg::KIND_FIN) begin
                    entry.op = fasmd_pkg::OP_PASS;
                end
                else begin
                    entry.kind = a.kind;
                end
            end
        endcase
        // A NaN result always carries a positive sign.
        if (entry.op == fasmd_pkg::OP_SPEC && entry.kind == fasmd_pkg::KIND_NAN) begin
            entry.sign = 1'b0;
        end
    end

endmodule

>>> rtl/core/fasmd_queue.sv
// Short queue of classified beats between the front and back ends.
// Depends on fasmd_pkg for the entry type.
module fasmd_queue #(
    parameter int DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  fasmd_pkg::entry_t    push_data,
    output logic                 full,
    input  logic                 pop,
    output fasmd_pkg::entry_t    pop_data,
    output logic                 empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    fasmd_pkg::entry_t mem [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> rtl/core/fasmd_back.sv
// Back end: multiplies, divides bit by bit, aligns and adds, normalises,
// rounds and packs the result into the output register. Depends on fasmd_pkg.
module fasmd_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 format_half,
    input  logic [1:0]           rounding_mode,
    input  logic                 queue_empty,
    input  fasmd_pkg::entry_t    queue_data,
    output logic                 pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 sign,
    output logic [1:0]           kind,
    output logic signed [8:0]    exponent,
    output logic [22:0]          fraction
);

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_MUL   = 7'b0000010,
        ST_DIV   = 7'b0000100,
        ST_ADD   = 7'b0001000,
        ST_NORM  = 7'b0010000,
        ST_ROUND = 7'b0100000,
        ST_PACK  = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    fasmd_pkg::entry_t ent_reg, ent_next;
    logic [56:0]       norm_reg, norm_next;
    fasmd_pkg::wexp_t  nexp_reg, nexp_next;
    logic              sticky_reg, sticky_next;
    logic              sign_reg, sign_next;
    logic              spec_reg, spec_next;
    logic [1:0]        skind_reg, skind_next;
    logic [24:0]       rem_reg, rem_next;
    logic [26:0]       quo_reg, quo_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [24:0]       mant_reg, mant_next;
    fasmd_pkg::wexp_t  q_reg, q_next;
    logic              out_valid_reg, out_valid_next;
    logic              out_sign_reg, out_sign_next;
    logic [1:0]        out_kind_reg, out_kind_next;
    logic [8:0]        out_exp_reg, out_exp_next;
    logic [22:0]       out_frac_reg, out_frac_next;

    // Format constants.
    logic [5:0]        prec;
    fasmd_pkg::wexp_t  emin;
    fasmd_pkg::wexp_t  emax;
    logic [22:0]       fmask;

    // Operand views.
    fasmd_pkg::wexp_t  ea;
    fasmd_pkg::wexp_t  eb;

    // Multiply.
    logic [47:0]       product;

    // Divide step.
    logic              div_ge;
    logic [24:0]       div_diff;

    // Alignment and add.
    logic              swap;
    logic [23:0]       big_m, small_m;
    fasmd_pkg::wexp_t  big_e, small_e, ediff;
    logic              big_s, small_s;
    logic [55:0]       small_w, small_sh, small_lost;
    logic [56:0]       addend, sum;

    // Rounding.
    fasmd_pkg::wexp_t  ebig, dsum;
    logic [5:0]        dsh, dm1;
    logic [63:0]       n64, shifted, restmask;
    logic              half_bit, rest, inc;
    logic [24:0]       mant0, mant1;

    // Packing.
    logic [4:0]        mp;
    logic [4:0]        shl;
    fasmd_pkg::wexp_t  xexp;
    logic [24:0]       fr;
    logic              to_inf;
    logic              out_free;

    assign prec  = format_half ? 6'd11 : 6'd24;
    assign emin  = format_half ? -12'sd14 : -12'sd126;
    assign emax  = format_half ? 12'sd15 : 12'sd127;
    assign fmask = format_half ? 23'h0003ff : 23'h7fffff;

    assign ea = fasmd_pkg::wexp_t'(ent_reg.exp_a);
    assign eb = fasmd_pkg::wexp_t'(ent_reg.exp_b);

    assign out_free = !out_valid_reg || out_ready;

    // Significand product.
    assign product = ent_reg.mant_a * ent_reg.mant_b;

    // One restoring division step.
    assign div_ge   = (rem_reg >= {1'b0, ent_reg.mant_b});
    assign div_diff = div_ge ? rem_reg - {1'b0, ent_reg.mant_b} : rem_reg;

    // Magnitude ordering, alignment with sticky jam, then the add.
    always_comb
    begin
        swap = (eb > ea) || ((eb == ea) && (ent_reg.mant_b > ent_reg.mant_a));
        big_m   = swap ? ent_reg.mant_b : ent_reg.mant_a;
        small_m = swap ? ent_reg.mant_a : ent_reg.mant_b;
        big_e   = swap ? eb : ea;
        small_e = swap ? ea : eb;
        big_s   = swap ? ent_reg.sign_b : ent_reg.sign;
        small_s = swap ? ent_reg.sign : ent_reg.sign_b;
        ediff   = big_e - small_e;
        small_w = {small_m, 32'b0};
        if (ediff >= 12'sd64) begin
            addend = 57'd1;
            small_sh   = '0;
            small_lost = '0;
        end
        else begin
            small_sh   = small_w >> ediff[5:0];
            small_lost = small_w & ((56'd1 << ediff[5:0]) - 56'd1);
            addend     = {1'b0, small_sh[55:1], small_sh[0] | (|small_lost)};
        end
        sum = (big_s == small_s) ? {1'b0, big_m, 32'b0} + addend
                                 : {1'b0, big_m, 32'b0} - addend;
    end

    // Rounding onto the format grid, subnormal range included.
    always_comb
    begin
        ebig     = (nexp_reg < emin) ? emin : nexp_reg;
        dsum     = fasmd_pkg::wexp_t'(7'd48 - {1'b0, prec}) + (ebig - nexp_reg);
        dsh      = (dsum > 12'sd63) ? 6'd63 : dsum[5:0];
        dm1      = dsh - 6'd1;
        n64      = {16'b0, norm_reg[56:9]};
        shifted  = n64 >> dsh;
        half_bit = n64[dm1];
        restmask = (64'd1 << dm1) - 64'd1;
        rest     = (|(n64 & restmask)) || sticky_reg || (|norm_reg[8:0]);
        mant0    = shifted[24:0];
        case (rounding_mode)
            fasmd_pkg::RM_NEAR: inc = half_bit && (rest || mant0[0]);
            fasmd_pkg::RM_UP:   inc = (half_bit || rest) && !sign_reg;
            fasmd_pkg::RM_DOWN: inc = (half_bit || rest) && sign_reg;
            default:            inc = 1'b0;
        endcase
        mant1 = mant0 + {24'b0, inc};
    end

    // Leading-one position of the rounded significand and final packing.
    always_comb
    begin
        mp = 5'd0;
        for (int i = 0; i < 25; i++) begin
            if (mant_reg[i]) begin
                mp = 5'(i);
            end
        end
        shl    = 5'(prec - 6'd1) - mp;
        xexp   = q_reg + fasmd_pkg::wexp_t'({7'b0, mp});
        fr     = mant_reg << shl;
        to_inf = (rounding_mode == fasmd_pkg::RM_NEAR)
              || ((rounding_mode == fasmd_pkg::RM_UP) && !sign_reg)
              || ((rounding_mode == fasmd_pkg::RM_DOWN) && sign_reg);
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        ent_next       = ent_reg;
        norm_next      = norm_reg;
        nexp_next      = nexp_reg;
        sticky_next    = sticky_reg;
        sign_next      = sign_reg;
        spec_next      = spec_reg;
        skind_next     = skind_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        cnt_next       = cnt_reg;
        mant_next      = mant_reg;
        q_next         = q_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_sign_next  = out_sign_reg;
        out_kind_next  = out_kind_reg;
        out_exp_next   = out_exp_reg;
        out_frac_next  = out_frac_reg;
        pop            = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (!queue_empty) begin
                    pop         = 1'b1;
                    ent_next    = queue_data;
                    sign_next   = queue_data.sign;
                    skind_next  = queue_data.kind;
                    sticky_next = 1'b0;
                    spec_next   = 1'b0;
                    case (queue_data.op)
                        fasmd_pkg::OP_PASS:
                        begin
                            norm_next  = {queue_data.mant_a, 33'b0};
                            nexp_next  = fasmd_pkg::wexp_t'(queue_data.exp_a) + 12'sd23;
                            state_next = ST_NORM;
                        end
                        fasmd_pkg::OP_MUL:
                        begin
                            state_next = ST_MUL;
                        end
                        fasmd_pkg::OP_DIV:
                        begin
                            rem_next   = {1'b0, queue_data.mant_a};
                            quo_next   = '0;
                            cnt_next   = '0;
                            state_next = ST_DIV;
                        end
                        fasmd_pkg::OP_ADD:
                        begin
                            state_next = ST_ADD;
                        end
                        default:
                        begin
                            spec_next  = 1'b1;
                            state_next = ST_PACK;
                        end
                    endcase
                end
            end
            ST_MUL:
            begin
                norm_next  = {1'b0, product, 8'b0};
                nexp_next  = ea + eb + 12'sd48;
                state_next = ST_NORM;
            end
            ST_DIV:
            begin
                rem_next = {div_diff[23:0], 1'b0};
                quo_next = {quo_reg[25:0], div_ge};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd26) begin
                    norm_next   = {quo_reg[25:0], div_ge, 30'b0};
                    nexp_next   = ea - eb;
                    sticky_next = (div_diff != '0);
                    state_next  = ST_NORM;
                end
            end
            ST_ADD:
            begin
                if (sum == '0) begin
                    spec_next  = 1'b1;
                    skind_next = fasmd_pkg::KIND_ZERO;
                    sign_next  = (rounding_mode == fasmd_pkg::RM_DOWN);
                    state_next = ST_PACK;
                end
                else begin
                    norm_next  = sum;
                    nexp_next  = big_e + 12'sd24;
                    sign_next  = big_s;
                    state_next = ST_NORM;
                end
            end
            ST_NORM:
            begin
                if (norm_reg[56]) begin
                    state_next = ST_ROUND;
                end
                else if (norm_reg[56:49] == 8'd0) begin
                    norm_next = norm_reg << 8;
                    nexp_next = nexp_reg - 12'sd8;
                end
                else begin
                    norm_next = norm_reg << 1;
                    nexp_next = nexp_reg - 12'sd1;
                end
            end
            ST_ROUND:
            begin
                q_next = ebig - fasmd_pkg::wexp_t'({6'b0, prec - 6'd1});
                if (mant1 == (25'd1 << prec)) begin
                    mant_next = mant1 >> 1;
                    q_next    = ebig - fasmd_pkg::wexp_t'({6'b0, prec - 6'd1}) + 12'sd1;
                end
                else begin
                    mant_next = mant1;
                end
                state_next = ST_PACK;
            end
            ST_PACK:
            begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_exp_next   = '0;
                    out_frac_next  = '0;
                    out_sign_next  = sign_reg;
                    if (spec_reg) begin
                        out_kind_next = skind_reg;
                        if (skind_reg == fasmd_pkg::KIND_NAN) begin
                            out_sign_next = 1'b0;
                        end
                    end
                    else if (mant_reg == '0) begin
                        out_kind_next = fasmd_pkg::KIND_ZERO;
                    end
                    else if (xexp > emax) begin
                        if (to_inf) begin
                            out_kind_next = fasmd_pkg::KIND_INF;
                        end
                        else begin
                            out_kind_next = fasmd_pkg::KIND_FIN;
                            out_exp_next  = emax[8:0];
                            out_frac_next = fmask;
                        end
                    end
                    else begin
                        out_kind_next = fasmd_pkg::KIND_FIN;
                        out_exp_next  = xexp[8:0];
                        out_frac_next = fr[22:0] & fmask;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        ent_reg      <= ent_next;
        norm_reg     <= norm_next;
        nexp_reg     <= nexp_next;
        sticky_reg   <= sticky_next;
        sign_reg     <= sign_next;
        spec_reg     <= spec_next;
        skind_reg    <= skind_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
        mant_reg     <= mant_next;
        q_reg        <= q_next;
        out_sign_reg <= out_sign_next;
        out_kind_reg <= out_kind_next;
        out_exp_reg  <= out_exp_next;
        out_frac_reg <= out_frac_next;
    end

    assign out_valid = out_valid_reg;
    assign sign      = out_sign_reg;
    assign kind      = out_kind_reg;
    assign exponent  = $signed(out_exp_reg);
    assign fraction  = out_frac_reg;

endmodule

>>> rtl/core/float_add_sub_mul_div_unit.sv
// Binary32/binary16 add, subtract, multiply, divide and pass unit.
// Special cases go straight to packing, as does an exact zero sum after the add; all
// other results go through a normalising shift loop, divides first through 27 restoring
// division steps; the back end works one item at a time while the queue takes beats.
// Reset (rst_n, asynchronous, active low) empties the queue and output and
// sets binary32 format with round to nearest even. Depends on fasmd_pkg.
module float_add_sub_mul_div_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic                 cfg_index,
    input  logic [1:0]           cfg_wdata,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           cmd,
    input  logic [31:0]          operand_a,
    input  logic [31:0]          operand_b,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 sign,
    output logic [1:0]           kind,
    output logic signed [8:0]    exponent,
    output logic [22:0]          fraction
);

    logic              format_half_reg;
    logic [1:0]        rounding_mode_reg;
    logic              push;
    logic              pop;
    logic              queue_full;
    logic              queue_empty;
    fasmd_pkg::entry_t push_data;
    fasmd_pkg::entry_t pop_data;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            format_half_reg   <= 1'b0;
            rounding_mode_reg <= fasmd_pkg::RM_NEAR;
        end
        else if (cfg_wr_en) begin
            if (cfg_index == fasmd_pkg::CFG_FORMAT) begin
                format_half_reg <= cfg_wdata[0];
            end
            else if (cfg_index == fasmd_pkg::CFG_ROUND) begin
                rounding_mode_reg <= cfg_wdata;
            end
        end
    end

    // Classify incoming beats.
    fasmd_front u_front (
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .operand_a     (operand_a),
        .operand_b     (operand_b),
        .format_half   (format_half_reg),
        .rounding_mode (rounding_mode_reg),
        .queue_full    (queue_full),
        .push          (push),
        .entry         (push_data)
    );

    // Decoupling queue.
    fasmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (queue_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (queue_empty)
    );

    // Arithmetic, rounding and output register.
    fasmd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .format_half   (format_half_reg),
        .rounding_mode (rounding_mode_reg),
        .queue_empty   (queue_empty),
        .queue_data    (pop_data),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sign          (sign),
        .kind          (kind),
        .exponent      (exponent),
        .fraction      (fraction)
    );

endmodule
